### rtl/core/nps_pkg.sv
`timescale 1ns / 1ps

package nps_pkg;

    localparam int MAX_CELLS      = 1024;
    localparam int COORD_BITS     = 20;
    localparam int SLOT_BITS      = 10;
    localparam int DIFF_BITS      = COORD_BITS + 1;
    localparam int DIST_BITS      = 2 * DIFF_BITS;
    localparam int CC_BITS        = 11;
    localparam int DIM_BITS       = 2;
    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_CELL_COUNT      = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIMENSION_COUNT = 1'b1;

    localparam logic [DIM_BITS-1:0] DIM_XYZ = 2'd3;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                         action;
        logic [SLOT_BITS-1:0]         cell_slot;
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] first_z;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
        logic signed [COORD_BITS-1:0] second_z;
    } nps_in_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0] nearest_cell;
        logic [DIST_BITS-1:0] least_distance_sq;
        logic                 already_claimed;
    } nps_out_t;

    typedef struct packed {
        logic [CC_BITS-1:0]  cell_count;
        logic [DIM_BITS-1:0] dimension_count;
    } nps_cfg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } nps_pos_t;

    // Travels alongside each cell as it moves through the distance pipeline.
    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last;
        logic [SLOT_BITS-1:0] index;
    } nps_tag_t;

    typedef struct packed {
        nps_tag_t             tag;
        logic [DIST_BITS-1:0] sq_dist;
    } nps_dist_t;

endpackage

### rtl/core/nearest_point_search.sv
`timescale 1ns / 1ps

// Nearest point search over a table of up to MAX_CELLS cell positions.
// Items enter through start/busy: an item transfers on a clock edge where
// start is high and busy is low. A load item (action 0) writes one cell
// position and clears its claim mark; it gives no result and busy stays low,
// so loads may follow each other every cycle.
// A query item (action 1) forms the midpoint of its two endpoints and scans
// cells 0 to n-1 through one pipelined distance unit, one cell per cycle
// from the position memory read port. Here n is cell_count, with zero taken
// as one and counts above MAX_CELLS taken as MAX_CELLS. The result is shown
// on result with done high for one cycle, once the last distance has left the
// pipeline and the claim mark of the winner has been read; busy falls at the
// end of that cycle. The receiver must take the result in that cycle.
// The user must write registers through cfg_we/cfg_index/cfg_data only while
// the block is idle; the block does not enforce this. Index 0 is cell_count,
// index 1 is dimension_count. After reset the block sweeps the claim memory
// clear, one entry per cycle, holding busy high through the sweep; register
// writes are taken then. Reset sets cell_count to 1, dimension_count to 3.
module nearest_point_search (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  nps_pkg::nps_in_t                     item,
    input  logic                                 cfg_we,
    input  logic [nps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [nps_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output logic                                 done,
    output nps_pkg::nps_out_t                    result
);

    import nps_pkg::*;

    localparam int AW = $clog2(MAX_CELLS);

    nps_cfg_t cfg_reg;

    logic          pos_we;
    logic [AW-1:0] pos_waddr, pos_raddr;
    nps_pos_t      pos_wdata, pos_rdata;
    logic          clm_we, clm_wdata, clm_rdata;
    logic [AW-1:0] clm_waddr, clm_raddr;
    nps_tag_t      tag;
    nps_pos_t      mid;
    logic          use_z;
    nps_dist_t     dist_bus;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_count      <= CC_BITS'(1);
            cfg_reg.dimension_count <= DIM_XYZ;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CELL_COUNT:
                begin
                    cfg_reg.cell_count <= cfg_data[CC_BITS-1:0];
                end
                REG_DIMENSION_COUNT:
                begin
                    cfg_reg.dimension_count <= cfg_data[DIM_BITS-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    nps_ram #(
        .WIDTH ($bits(nps_pos_t)),
        .DEPTH (MAX_CELLS)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    nps_ram #(
        .WIDTH (1),
        .DEPTH (MAX_CELLS)
    ) u_claim_ram (
        .clk   (clk),
        .we    (clm_we),
        .waddr (clm_waddr),
        .wdata (clm_wdata),
        .raddr (clm_raddr),
        .rdata (clm_rdata)
    );

    nps_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg       (cfg_reg),
        .pos_we    (pos_we),
        .pos_waddr (pos_waddr),
        .pos_wdata (pos_wdata),
        .pos_raddr (pos_raddr),
        .tag_out   (tag),
        .mid       (mid),
        .use_z     (use_z),
        .dist_in   (dist_bus),
        .clm_we    (clm_we),
        .clm_waddr (clm_waddr),
        .clm_wdata (clm_wdata),
        .clm_raddr (clm_raddr),
        .clm_rdata (clm_rdata),
        .done      (done),
        .result    (result)
    );

    nps_dist_unit u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .use_z    (use_z),
        .mid      (mid),
        .tag_in   (tag),
        .pos_in   (pos_rdata),
        .dist_out (dist_bus)
    );

endmodule

### rtl/core/nps_ram.sv
`timescale 1ns / 1ps

module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/nps_dist_unit.sv
`timescale 1ns / 1ps

module nps_dist_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              use_z,
    input  nps_pkg::nps_pos_t mid,
    input  nps_pkg::nps_tag_t tag_in,
    input  nps_pkg::nps_pos_t pos_in,
    output nps_pkg::nps_dist_t dist_out
);

    import nps_pkg::*;

    nps_tag_t tag1_reg, tag2_reg, tag3_reg;

    logic signed [DIFF_BITS-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [DIFF_BITS-1:0] dx_next, dy_next, dz_next;

    logic signed [DIST_BITS-1:0] px, py, pz;
    logic [DIST_BITS-1:0] sx_reg, sy_reg, sz_reg;
    logic [DIST_BITS-1:0] sum_reg, sum_next;

    // Differences are one bit wider than the coordinates so they never wrap.
    always_comb
    begin
        dx_next = {mid.x[COORD_BITS-1], mid.x} - {pos_in.x[COORD_BITS-1], pos_in.x};
        dy_next = {mid.y[COORD_BITS-1], mid.y} - {pos_in.y[COORD_BITS-1], pos_in.y};
        if (use_z)
        begin
            dz_next = {mid.z[COORD_BITS-1], mid.z} - {pos_in.z[COORD_BITS-1], pos_in.z};
        end
        else
        begin
            dz_next = '0;
        end
    end

    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;
    assign pz = dz_reg * dz_reg;

    // Each square is at most 2^40, so the sum of three fits the result width.
    assign sum_next = sx_reg + sy_reg + sz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        dz_reg  <= dz_next;
        sx_reg  <= DIST_BITS'(px);
        sy_reg  <= DIST_BITS'(py);
        sz_reg  <= DIST_BITS'(pz);
        sum_reg <= sum_next;
    end

    assign dist_out.tag     = tag3_reg;
    assign dist_out.sq_dist = sum_reg;

endmodule

### rtl/core/nps_seq.sv
`timescale 1ns / 1ps

module nps_seq (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  nps_pkg::nps_in_t                      item,
    input  nps_pkg::nps_cfg_t                     cfg,
    output logic                                  pos_we,
    output logic [$clog2(nps_pkg::MAX_CELLS)-1:0] pos_waddr,
    output nps_pkg::nps_pos_t                     pos_wdata,
    output logic [$clog2(nps_pkg::MAX_CELLS)-1:0] pos_raddr,
    output nps_pkg::nps_tag_t                     tag_out,
    output nps_pkg::nps_pos_t                     mid,
    output logic                                  use_z,
    input  nps_pkg::nps_dist_t                    dist_in,
    output logic                                  clm_we,
    output logic [$clog2(nps_pkg::MAX_CELLS)-1:0] clm_waddr,
    output logic                                  clm_wdata,
    output logic [$clog2(nps_pkg::MAX_CELLS)-1:0] clm_raddr,
    input  logic                                  clm_rdata,
    output logic                                  done,
    output nps_pkg::nps_out_t                     result
);

    import nps_pkg::*;

    localparam int AW       = $clog2(MAX_CELLS);
    localparam int CNT_BITS = $clog2(MAX_CELLS + 1);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_CLAIM = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]       clr_reg, clr_next;
    logic [CNT_BITS-1:0] iss_reg, iss_next;
    logic [CNT_BITS-1:0] n_eff, n_last;
    nps_tag_t            tag_reg, tag_next;
    nps_pos_t            mid_reg, mid_next;
    logic [SLOT_BITS-1:0] best_reg, best_next;
    logic [DIST_BITS-1:0] best_dist_reg, best_dist_next;

    logic slot_ok;
    logic [COORD_BITS:0] sum_x, sum_y, sum_z;

    // A cell count of zero scans one cell; a count past the table saturates.
    always_comb
    begin
        if (cfg.cell_count == '0)
        begin
            n_eff = CNT_BITS'(1);
        end
        else if (32'(cfg.cell_count) > MAX_CELLS)
        begin
            n_eff = CNT_BITS'(MAX_CELLS);
        end
        else
        begin
            n_eff = CNT_BITS'(cfg.cell_count);
        end
    end

    assign n_last  = n_eff - CNT_BITS'(1);
    assign slot_ok = 32'(item.cell_slot) < MAX_CELLS;
    assign use_z   = (cfg.dimension_count == DIM_XYZ);

    // Midpoint: the top bits of the widened sum give floor((a + b) / 2).
    assign sum_x = {item.first_x[COORD_BITS-1], item.first_x}
                 + {item.second_x[COORD_BITS-1], item.second_x};
    assign sum_y = {item.first_y[COORD_BITS-1], item.first_y}
                 + {item.second_y[COORD_BITS-1], item.second_y};
    assign sum_z = {item.first_z[COORD_BITS-1], item.first_z}
                 + {item.second_z[COORD_BITS-1], item.second_z};

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        iss_next       = iss_reg;
        mid_next       = mid_reg;
        tag_next       = '0;
        pos_we         = 1'b0;
        pos_waddr      = AW'(item.cell_slot);
        pos_wdata.x    = item.first_x;
        pos_wdata.y    = item.first_y;
        pos_wdata.z    = item.first_z;
        clm_we         = 1'b0;
        clm_waddr      = clr_reg;
        clm_wdata      = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clm_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(MAX_CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (item.action == ACT_LOAD)
                    begin
                        // Loading a cell also clears its claim mark.
                        if (slot_ok)
                        begin
                            pos_we    = 1'b1;
                            clm_we    = 1'b1;
                            clm_waddr = AW'(item.cell_slot);
                        end
                    end
                    else
                    begin
                        mid_next.x = sum_x[COORD_BITS:1];
                        mid_next.y = sum_y[COORD_BITS:1];
                        mid_next.z = sum_z[COORD_BITS:1];
                        iss_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                tag_next.valid = 1'b1;
                tag_next.first = (iss_reg == '0);
                tag_next.last  = (iss_reg == n_last);
                tag_next.index = SLOT_BITS'(iss_reg);
                iss_next       = iss_reg + 1'b1;
                if (iss_reg == n_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (dist_in.tag.valid && dist_in.tag.last)
                begin
                    state_next = ST_CLAIM;
                end
            end
            ST_CLAIM:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                clm_we     = 1'b1;
                clm_waddr  = AW'(best_reg);
                clm_wdata  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Strict less-than keeps the lowest index on a tie.
    always_comb
    begin
        best_next      = best_reg;
        best_dist_next = best_dist_reg;
        if (dist_in.tag.valid && (dist_in.tag.first || dist_in.sq_dist < best_dist_reg))
        begin
            best_next      = dist_in.tag.index;
            best_dist_next = dist_in.sq_dist;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            iss_reg   <= '0;
            tag_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            iss_reg   <= iss_next;
            tag_reg   <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg       <= mid_next;
        best_reg      <= best_next;
        best_dist_reg <= best_dist_next;
    end

    assign pos_raddr = AW'(iss_reg);
    assign clm_raddr = AW'(best_reg);
    assign tag_out   = tag_reg;
    assign mid       = mid_reg;

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    assign result.nearest_cell      = best_reg;
    assign result.least_distance_sq = best_dist_reg;
    assign result.already_claimed   = clm_rdata;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import nps_pkg::*;

    localparam int  CLK_PERIOD    = 12;
    localparam int  SETTLE_CYCLES = 16;
    localparam int  CMAX          = (1 << (COORD_BITS - 1)) - 1;
    localparam int  CMIN          = -(1 << (COORD_BITS - 1));
    localparam longint LIMIT_NS   = 64'd12_000_000;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        nps_in_t                   item;
        logic [CFG_INDEX_BITS-1:0] reg_index;
        logic [CFG_DATA_BITS-1:0]  reg_value;
        bit                        typed;
        nps_out_t                  want;
    } plan_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    nps_in_t                   item;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      done;
    nps_out_t                  result;

    // Predictor state: the cell table, the claim marks and both registers.
    nps_pos_t            cell_pos [MAX_CELLS];
    bit                  claim_mark [MAX_CELLS];
    logic [CC_BITS-1:0]  count_cfg;
    logic [DIM_BITS-1:0] dims_cfg;

    nps_out_t  pending_results [$];
    nps_out_t  oldest_expected;
    plan_row_t directed_plan [$];

    int idle_pct;
    int error_count;
    int results_checked;
    int load_count;
    int query_count;
    int cfg_writes;

    nearest_point_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int scan_span();
        if (count_cfg == 0)
            return 1;
        if (count_cfg > MAX_CELLS)
            return MAX_CELLS;
        return count_cfg;
    endfunction

    // Applies one transfer to the predictor state; returns 1 when a result is due.
    function automatic bit predict_nearest(input nps_in_t it, output nps_out_t res);
        longint mx, my, mz, dx, dy, dz, d, best_d;
        int     n, best;
        res = '0;
        if (it.action == ACT_LOAD) begin
            cell_pos[it.cell_slot].x = it.first_x;
            cell_pos[it.cell_slot].y = it.first_y;
            cell_pos[it.cell_slot].z = it.first_z;
            claim_mark[it.cell_slot] = 1'b0;
            return 1'b0;
        end
        // The midpoint floors toward minus infinity.
        mx = (longint'($signed(it.first_x)) + longint'($signed(it.second_x))) >>> 1;
        my = (longint'($signed(it.first_y)) + longint'($signed(it.second_y))) >>> 1;
        mz = (longint'($signed(it.first_z)) + longint'($signed(it.second_z))) >>> 1;
        n = scan_span();
        best = 0;
        best_d = 0;
        for (int i = 0; i < n; i++) begin
            dx = mx - longint'($signed(cell_pos[i].x));
            dy = my - longint'($signed(cell_pos[i].y));
            dz = mz - longint'($signed(cell_pos[i].z));
            d = dx * dx + dy * dy;
            if (dims_cfg == DIM_XYZ)
                d += dz * dz;
            if (i == 0 || d < best_d) begin
                best_d = d;
                best = i;
            end
        end
        res.nearest_cell      = best[SLOT_BITS-1:0];
        res.least_distance_sq = best_d[DIST_BITS-1:0];
        res.already_claimed   = claim_mark[best];
        claim_mark[best] = 1'b1;
        return 1'b1;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] random_coord();
        case ($urandom_range(0, 5))
            0:       return COORD_BITS'(CMAX);
            1:       return COORD_BITS'(CMIN);
            2, 3:    return COORD_BITS'(int'($urandom_range(0, 127)) - 64);
            default: return COORD_BITS'($urandom());
        endcase
    endfunction

    // Two endpoints whose midpoint falls on or right next to the given coordinate.
    function automatic logic [2*COORD_BITS-1:0] straddle(input int center);
        int off, a, b;
        off = int'($urandom_range(0, 200)) - 100;
        a = center + off;
        b = center - off + int'($urandom_range(0, 2)) - 1;
        if (a > CMAX) a = CMAX;
        if (a < CMIN) a = CMIN;
        if (b > CMAX) b = CMAX;
        if (b < CMIN) b = CMIN;
        return {COORD_BITS'(a), COORD_BITS'(b)};
    endfunction

    function automatic nps_in_t random_item();
        nps_in_t it;
        int      span, k;
        span = scan_span();
        it.action = ($urandom_range(0, 99) < 55) ? ACT_QUERY : ACT_LOAD;
        // Loads mostly land inside the scanned range so they move the answer.
        if ($urandom_range(0, 3) != 0)
            it.cell_slot = SLOT_BITS'($urandom_range(0, span - 1));
        else
            it.cell_slot = SLOT_BITS'($urandom());
        it.first_x  = random_coord();
        it.first_y  = random_coord();
        it.first_z  = random_coord();
        it.second_x = random_coord();
        it.second_y = random_coord();
        it.second_z = random_coord();
        if (it.action == ACT_QUERY && $urandom_range(0, 2) != 0) begin
            k = $urandom_range(0, span - 1);
            {it.first_x, it.second_x} = straddle($signed(cell_pos[k].x));
            {it.first_y, it.second_y} = straddle($signed(cell_pos[k].y));
            {it.first_z, it.second_z} = straddle($signed(cell_pos[k].z));
        end
        return it;
    endfunction

    function automatic plan_row_t load_row(input int slot, input int x, input int y,
                                           input int z);
        plan_row_t r;
        r = '{kind: ROW_ITEM, item: '0, reg_index: '0, reg_value: '0, typed: 1'b0,
              want: '0};
        r.item.action    = ACT_LOAD;
        r.item.cell_slot = SLOT_BITS'(slot);
        r.item.first_x   = COORD_BITS'(x);
        r.item.first_y   = COORD_BITS'(y);
        r.item.first_z   = COORD_BITS'(z);
        return r;
    endfunction

    function automatic plan_row_t query_row(input int x1, input int y1, input int z1,
                                            input int x2, input int y2, input int z2,
                                            input bit typed = 1'b0, input int cell_idx = 0,
                                            input longint dist_sq = 0,
                                            input bit claimed = 1'b0);
        plan_row_t r;
        r = '{kind: ROW_ITEM, item: '0, reg_index: '0, reg_value: '0, typed: typed,
              want: '0};
        r.item.action   = ACT_QUERY;
        r.item.first_x  = COORD_BITS'(x1);
        r.item.first_y  = COORD_BITS'(y1);
        r.item.first_z  = COORD_BITS'(z1);
        r.item.second_x = COORD_BITS'(x2);
        r.item.second_y = COORD_BITS'(y2);
        r.item.second_z = COORD_BITS'(z2);
        r.want.nearest_cell      = SLOT_BITS'(cell_idx);
        r.want.least_distance_sq = DIST_BITS'(dist_sq);
        r.want.already_claimed   = claimed;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                          input int value);
        plan_row_t r;
        r = '{kind: ROW_CFG, item: '0, reg_index: idx, reg_value: CFG_DATA_BITS'(value),
              typed: 1'b0, want: '0};
        return r;
    endfunction

    task automatic send_item(input nps_in_t it, input bit typed, input nps_out_t typed_want);
        nps_out_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        item  = it;
        do
            @(posedge clk);
        while (busy);
        if (predict_nearest(it, predicted)) begin
            pending_results.push_back(typed ? typed_want : predicted);
            query_count++;
        end else begin
            load_count++;
        end
    endtask

    // Holds the sender off until every query has answered and the block is idle.
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0 || busy)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        settle();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        if (idx == REG_CELL_COUNT)
            count_cfg = value[CC_BITS-1:0];
        else
            dims_cfg = value[DIM_BITS-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        cfg_writes++;
    endtask

    always @(posedge clk) begin
        if (rst_n && done) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                $error("result transfer with no query outstanding: cell %0d",
                       result.nearest_cell);
                error_count++;
            end else begin
                oldest_expected = pending_results.pop_front();
                if (result.nearest_cell !== oldest_expected.nearest_cell) begin
                    $error("nearest_cell: expected %0d, actual %0d",
                           oldest_expected.nearest_cell, result.nearest_cell);
                    error_count++;
                end
                if (result.least_distance_sq !== oldest_expected.least_distance_sq) begin
                    $error("least_distance_sq: expected %0d, actual %0d",
                           oldest_expected.least_distance_sq, result.least_distance_sq);
                    error_count++;
                end
                if (result.already_claimed !== oldest_expected.already_claimed) begin
                    $error("already_claimed: expected %0d, actual %0d",
                           oldest_expected.already_claimed, result.already_claimed);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        nps_in_t             fill;
        nps_out_t            no_want;
        int                  span_value;
        int                  n_items;
        logic [DIM_BITS-1:0] dim_value;

        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        no_want   = '0;
        idle_pct  = 0;
        error_count     = 0;
        results_checked = 0;
        load_count      = 0;
        query_count     = 0;
        cfg_writes      = 0;
        count_cfg = CC_BITS'(1);
        dims_cfg  = DIM_XYZ;
        for (int i = 0; i < MAX_CELLS; i++) begin
            cell_pos[i]   = '0;
            claim_mark[i] = 1'b0;
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Every cell gets a position before any query can scan it.
        for (int s = 0; s < MAX_CELLS; s++) begin
            fill.action    = ACT_LOAD;
            fill.cell_slot = SLOT_BITS'(s);
            fill.first_x   = random_coord();
            fill.first_y   = random_coord();
            fill.first_z   = random_coord();
            fill.second_x  = random_coord();
            fill.second_y  = random_coord();
            fill.second_z  = random_coord();
            send_item(fill, 1'b0, no_want);
        end

        // Rows up to the first register write run on the reset settings.
        directed_plan.push_back(load_row(0, 0, 0, 0));
        directed_plan.push_back(query_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        directed_plan.push_back(query_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 1));
        directed_plan.push_back(load_row(0, CMAX, CMAX, CMAX));
        directed_plan.push_back(query_row(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                                          1, 0, 64'd3298528591875, 0));
        directed_plan.push_back(query_row(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
                                          1, 0, 64'd824633720832, 1));
        directed_plan.push_back(load_row(1, 10, 0, 0));
        directed_plan.push_back(load_row(2, -10, 0, 0));
        directed_plan.push_back(cfg_row(REG_CELL_COUNT, 3));
        // Cells 1 and 2 tie; the lower index has to win.
        directed_plan.push_back(query_row(0, 0, 0, 1, 1, 1, 1, 1, 100, 0));
        directed_plan.push_back(cfg_row(REG_DIMENSION_COUNT, 2));
        directed_plan.push_back(query_row(10, 0, 400000, 10, 0, 400001, 1, 1, 0, 1));
        directed_plan.push_back(cfg_row(REG_DIMENSION_COUNT, 0));
        directed_plan.push_back(query_row(-3, -7, 5, 4, 9, -100));
        directed_plan.push_back(cfg_row(REG_DIMENSION_COUNT, 1));
        directed_plan.push_back(query_row(CMIN, CMAX, 0, CMIN, CMAX, 0));
        directed_plan.push_back(cfg_row(REG_CELL_COUNT, 0));
        directed_plan.push_back(query_row(9, 1, 2, 11, -1, -2));
        directed_plan.push_back(load_row(MAX_CELLS - 1, CMIN, CMAX, -1));
        directed_plan.push_back(cfg_row(REG_CELL_COUNT, 2047));
        directed_plan.push_back(cfg_row(REG_DIMENSION_COUNT, DIM_XYZ));
        directed_plan.push_back(query_row(CMIN, CMAX, -1, CMIN, CMAX, -1));
        directed_plan.push_back(cfg_row(REG_CELL_COUNT, MAX_CELLS));
        directed_plan.push_back(query_row(CMIN, CMAX, -1, CMIN + 1, CMAX - 1, -2));

        idle_pct = 30;
        foreach (directed_plan[r]) begin
            if (directed_plan[r].kind == ROW_CFG)
                write_register(directed_plan[r].reg_index, directed_plan[r].reg_value);
            else
                send_item(directed_plan[r].item, directed_plan[r].typed,
                          directed_plan[r].want);
        end

        // Random phases: sender idles 30%, then 75%, then never.
        for (int phase = 0; phase < 12; phase++) begin
            idle_pct = (phase < 4) ? 30 : (phase < 8) ? 75 : 0;
            case (phase)
                2:       span_value = 2047;
                5:       span_value = 0;
                6:       span_value = MAX_CELLS;
                9:       span_value = $urandom_range(MAX_CELLS + 1, 2047);
                default: span_value = $urandom_range(1, 40);
            endcase
            dim_value = $urandom_range(0, 1) ? DIM_XYZ : DIM_BITS'($urandom_range(0, 2));
            write_register(REG_CELL_COUNT, CFG_DATA_BITS'(span_value));
            write_register(REG_DIMENSION_COUNT, CFG_DATA_BITS'(dim_value));
            // Full-table scans are slow, so those phases stay short.
            n_items = (span_value >= MAX_CELLS) ? 12 : 60;
            for (int n = 0; n < n_items; n++)
                send_item(random_item(), 1'b0, no_want);
        end

        settle();
        $display("Run covered %0d cell loads and %0d queries across %0d register writes,",
                 load_count, query_count, cfg_writes);
        $display("with %0d query results compared field by field.", results_checked);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
